FILE: design/b64lw_pkg.sv
// ----------------------------------------------------------------------------
// b64lw_pkg
// Shared types, character codes and the Base64 alphabet for the line-wrapping
// encoder.
// ----------------------------------------------------------------------------
package b64lw_pkg;

    localparam int unsigned BURST_CHARS = 8;
    localparam int unsigned COUNT_W     = $clog2(BURST_CHARS + 1);
    localparam int unsigned IDX_W       = $clog2(BURST_CHARS);

    localparam logic [5:0] LINE_GROUPS_RESET = 6'd19;

    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_PAD = 8'd61;

    // encoder state carried between beats
    typedef struct packed {
        logic [15:0] held_bytes;
        logic [1:0]  held_count;
        logic [5:0]  line_group_count;
    } enc_state_t;

    // all characters caused by one input beat
    typedef struct packed {
        logic [BURST_CHARS-1:0][7:0] chars;
        logic [COUNT_W-1:0]          count;
        logic                        last;
    } burst_t;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] c;
        begin
            w = {2'b00, v};
            if (v < 6'd26)
                c = w + 8'd65;
            else if (v < 6'd52)
                c = w + 8'd71;
            else if (v < 6'd62)
                c = w - 8'd4;
            else if (v == 6'd62)
                c = 8'd43;
            else
                c = 8'd47;
            return c;
        end
    endfunction

endpackage

FILE: design/b64lw_group.sv
// ----------------------------------------------------------------------------
// b64lw_group
// Builds the character burst for one input byte and the encoder state that
// follows it.
// ----------------------------------------------------------------------------
module b64lw_group
    import b64lw_pkg::*;
(
    input  enc_state_t cur,
    input  logic [5:0] line_groups,
    input  logic [7:0] data_byte,
    input  logic       msg_last,
    output burst_t     burst,
    output enc_state_t nxt
);

    logic       full;
    logic [5:0] cnt_inc;
    logic       wrap;
    logic [1:0] new_count;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] p0;
    logic [7:0] p1;

    assign full      = (cur.held_count == 2'd2);
    assign cnt_inc   = cur.line_group_count + 6'd1;
    assign wrap      = (line_groups != 6'd0) && (cnt_inc >= line_groups);
    assign new_count = cur.held_count + 2'd1;
    assign b0        = cur.held_bytes[15:8];
    assign b1        = cur.held_bytes[7:0];
    // bytes of a partial group on the last beat
    assign p0        = (new_count == 2'd1) ? data_byte : b1;
    assign p1        = data_byte;

    always_comb
    begin
        burst.chars = '0;
        burst.count = '0;
        burst.last  = msg_last;
        nxt         = cur;
        if (full)
        begin
            burst.chars[0] = b64_char(b0[7:2]);
            burst.chars[1] = b64_char({b0[1:0], b1[7:4]});
            burst.chars[2] = b64_char({b1[3:0], data_byte[7:6]});
            burst.chars[3] = b64_char(data_byte[5:0]);
            nxt.held_bytes = '0;
            nxt.held_count = '0;
            if (wrap)
            begin
                burst.chars[4]       = CH_CR;
                burst.chars[5]       = CH_LF;
                nxt.line_group_count = '0;
                if (msg_last)
                begin
                    burst.chars[6] = CH_CR;
                    burst.chars[7] = CH_LF;
                    burst.count    = COUNT_W'(8);
                end
                else
                begin
                    burst.count = COUNT_W'(6);
                end
            end
            else
            begin
                nxt.line_group_count = cnt_inc;
                if (msg_last)
                begin
                    burst.chars[4] = CH_CR;
                    burst.chars[5] = CH_LF;
                    burst.count    = COUNT_W'(6);
                end
                else
                begin
                    burst.count = COUNT_W'(4);
                end
            end
        end
        else
        begin
            nxt.held_bytes = {cur.held_bytes[7:0], data_byte};
            nxt.held_count = new_count;
            if (msg_last)
            begin
                burst.chars[0] = b64_char(p0[7:2]);
                if (new_count == 2'd1)
                begin
                    burst.chars[1] = b64_char({p0[1:0], 4'd0});
                    burst.chars[2] = CH_PAD;
                end
                else
                begin
                    burst.chars[1] = b64_char({p0[1:0], p1[7:4]});
                    burst.chars[2] = b64_char({p1[3:0], 2'd0});
                end
                burst.chars[3] = CH_PAD;
                burst.chars[4] = CH_CR;
                burst.chars[5] = CH_LF;
                burst.count    = COUNT_W'(6);
            end
        end
        if (msg_last)
        begin
            nxt.held_bytes       = '0;
            nxt.held_count       = '0;
            nxt.line_group_count = '0;
        end
    end

endmodule

FILE: design/b64lw_outq.sv
// ----------------------------------------------------------------------------
// b64lw_outq
// One waiting burst slot in front of the active burst, which is sent out one
// character per beat.
// ----------------------------------------------------------------------------
module b64lw_outq
    import b64lw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  burst_t     push_burst,
    output logic       ready,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       out_last
);

    burst_t             pend_reg;
    logic               pend_valid_reg;
    burst_t             act_reg;
    logic               act_valid_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               sent;
    logic               at_end;
    logic               fin;
    logic               move;

    assign sent   = act_valid_reg && !out_stall;
    assign at_end = ({1'b0, idx_reg} + COUNT_W'(1)) == act_reg.count;
    assign fin    = sent && at_end;
    assign move   = pend_valid_reg && (!act_valid_reg || fin);
    assign ready  = !pend_valid_reg || move;

    assign out_valid = act_valid_reg;
    assign out_char  = act_reg.chars[idx_reg];
    assign out_last  = act_reg.last && at_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            act_valid_reg  <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            if (push)
                pend_valid_reg <= 1'b1;
            else if (move)
                pend_valid_reg <= 1'b0;

            if (move)
            begin
                act_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (fin)
            begin
                act_valid_reg <= 1'b0;
                idx_reg       <= '0;
            end
            else if (sent)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            pend_reg <= push_burst;
        if (move)
            act_reg <= pend_reg;
    end

endmodule

FILE: design/base64_line_wrap_encoder.sv
// ----------------------------------------------------------------------------
// base64_line_wrap_encoder
// Streaming Base64 encoder with CR LF line wrapping every line_groups groups
// and a closing CR LF on the last byte of each message.
// ----------------------------------------------------------------------------
//  channel   signals                         handshake
//  input     data_byte, msg_last             in_valid / in_stall
//  output    out_char, out_last              out_valid / out_stall
//  config    line_groups                     cfg_valid / cfg_ready
//
//  A byte is encoded in the cycle it is taken; its burst (0 to 8 characters)
//  goes to a one-entry slot ahead of the output burst register, and its first
//  character is offered once the burst moves from the slot into that register.
//  Output runs one character per beat, so throughput is set by the output
//  side; a closing byte yields a burst of 6 or 8 characters. Input stalls
//  while the slot is full, except in a cycle where the active burst is empty
//  or its final character leaves. Reset clears the encoder state and the
//  valid flags, and sets line_groups to 19.
// ----------------------------------------------------------------------------
module base64_line_wrap_encoder
    import b64lw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       msg_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       out_last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [5:0] line_groups
);

    enc_state_t state_reg;
    enc_state_t state_next;
    logic [5:0] line_groups_reg;
    burst_t     burst;
    logic       q_ready;
    logic       accept;
    logic       push;

    assign cfg_ready = 1'b1;
    assign in_stall  = !q_ready;
    assign accept    = in_valid && q_ready;
    // beats that only park a byte produce no burst
    assign push      = accept && (burst.count != '0);

    b64lw_group u_group (
        .cur         (state_reg),
        .line_groups (line_groups_reg),
        .data_byte   (data_byte),
        .msg_last    (msg_last),
        .burst       (burst),
        .nxt         (state_next)
    );

    b64lw_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_burst (burst),
        .ready      (q_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .out_last   (out_last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= '0;
            line_groups_reg <= LINE_GROUPS_RESET;
        end
        else
        begin
            if (accept)
                state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                line_groups_reg <= line_groups;
        end
    end

endmodule
